// ===== rtl/core/xcr_pkg.sv =====
// Shared types, codes and constants of the XMODEM checksum receiver.
package xcr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int GRP_MAX       = 3;

    localparam logic [7:0]  PAYLOAD_LAST  = 8'(PAYLOAD_BYTES);
    localparam logic [23:0] TICK_MAX      = 24'hFF_FFFF;
    localparam logic [7:0]  RETRY_MAX     = 8'hFF;
    localparam logic [23:0] TIMEOUT_RESET = 24'd1000;
    localparam logic [7:0]  RETRY_RESET   = 8'd10;
    localparam logic [7:0]  BLOCK_FIRST   = 8'd1;

    // Protocol characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_ESC = 8'h1B;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_SEND     = 2'd1;
    localparam logic [1:0] KIND_VERIFIED = 2'd2;
    localparam logic [1:0] KIND_ENDED    = 2'd3;

    // End status codes.
    localparam logic [1:0] END_EOT     = 2'd0;
    localparam logic [1:0] END_CANCEL  = 2'd1;
    localparam logic [1:0] END_RETRIES = 2'd2;
    localparam logic [1:0] END_SINK    = 2'd3;
    localparam logic [1:0] END_NONE    = 2'd0;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_VERDICT = 2'd2;

    typedef enum logic [1:0] {
        REQ_START,
        REQ_BYTE,
        REQ_TICK,
        REQ_VERDICT
    } req_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_BLOCK,
        PH_BLOCK_INV,
        PH_PAYLOAD,
        PH_CHECKSUM,
        PH_VERDICT
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] status;
    } res_t;

    // All results caused by one input item, in order from index 0.
    typedef struct packed {
        logic [1:0]               cnt;
        res_t [GRP_MAX-1:0]       res;
    } grp_t;

    function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data, logic [1:0] status);
        res_t r;
        r.kind   = kind;
        r.data   = data;
        r.status = status;
        return r;
    endfunction

endpackage

// ===== rtl/core/xcr_proto.sv =====
// Input register, configuration registers and the receiver protocol engine.
module xcr_proto import xcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        q_full,
    output logic        grp_push,
    output grp_t        grp_out
);

    logic        in_valid_reg, in_valid_next;
    req_t        in_req_reg;
    logic [7:0]  in_byte_reg;
    logic        in_acc_reg;

    logic [23:0] timeout_reg;
    logic [7:0]  retry_limit_reg;
    logic        verdict_en_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  exp_block_reg, exp_block_next;
    logic [7:0]  recv_block_reg, recv_block_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  retries_reg, retries_next;
    logic [23:0] elapsed_reg, elapsed_next;

    logic        fire, s_take;
    logic        req_byte, req_tick, req_verdict;
    logic        in_packet;
    logic [23:0] elapsed_inc;
    logic [7:0]  retries_inc;
    logic [7:0]  count_inc;
    logic        fail_end;
    logic        ev_start, ev_eot, ev_esc, ev_soh, ev_blk_byte, ev_blk_ok;
    logic        ev_payload, ev_verified, ev_ack, ev_abort, ev_fail;
    logic        bad_block, bad_sum, sum_ok, timed_out;

    assign fire      = in_valid_reg && !q_full;
    assign s_tready  = !in_valid_reg || fire;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Event decode of the item held in the input register.
    assign req_byte    = fire && (in_req_reg == REQ_BYTE);
    assign req_tick    = fire && (in_req_reg == REQ_TICK);
    assign req_verdict = fire && (in_req_reg == REQ_VERDICT) && (phase_reg == PH_VERDICT);
    assign in_packet   = (phase_reg == PH_HUNT) || (phase_reg == PH_BLOCK) ||
                         (phase_reg == PH_BLOCK_INV) || (phase_reg == PH_PAYLOAD) ||
                         (phase_reg == PH_CHECKSUM);

    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 24'd1;
    assign retries_inc = (retries_reg == RETRY_MAX) ? retries_reg : retries_reg + 8'd1;
    assign count_inc   = count_reg + 8'd1;
    assign fail_end    = retries_inc >= retry_limit_reg;

    assign ev_start    = fire && (in_req_reg == REQ_START);
    assign ev_eot      = req_byte && (phase_reg == PH_HUNT) && (in_byte_reg == CH_EOT);
    assign ev_esc      = req_byte && (phase_reg == PH_HUNT) && (in_byte_reg == CH_ESC);
    assign ev_soh      = req_byte && (phase_reg == PH_HUNT) && (in_byte_reg == CH_SOH);
    assign ev_blk_byte = req_byte && (phase_reg == PH_BLOCK);
    assign bad_block   = (recv_block_reg != exp_block_reg) || (~in_byte_reg != exp_block_reg);
    assign ev_blk_ok   = req_byte && (phase_reg == PH_BLOCK_INV) && !bad_block;
    assign ev_payload  = req_byte && (phase_reg == PH_PAYLOAD);
    assign sum_ok      = in_byte_reg == sum_reg;
    assign bad_sum     = req_byte && (phase_reg == PH_CHECKSUM) && !sum_ok;
    assign ev_verified = req_byte && (phase_reg == PH_CHECKSUM) && sum_ok && verdict_en_reg;
    assign timed_out   = req_tick && in_packet && (elapsed_inc >= timeout_reg);
    assign ev_fail     = (req_byte && (phase_reg == PH_BLOCK_INV) && bad_block) ||
                         bad_sum || timed_out;
    assign ev_ack      = (req_byte && (phase_reg == PH_CHECKSUM) && sum_ok && !verdict_en_reg) ||
                         (req_verdict && in_acc_reg);
    assign ev_abort    = req_verdict && !in_acc_reg;

    // Next state.
    always_comb begin
        phase_next      = phase_reg;
        exp_block_next  = exp_block_reg;
        recv_block_next = recv_block_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        retries_next    = retries_reg;
        elapsed_next    = elapsed_reg;

        if (req_tick && in_packet) begin
            elapsed_next = elapsed_inc;
        end
        if (ev_start) begin
            exp_block_next  = BLOCK_FIRST;
            retries_next    = 8'd0;
            recv_block_next = 8'd0;
            phase_next      = PH_HUNT;
            elapsed_next    = 24'd0;
            count_next      = 8'd0;
            sum_next        = 8'd0;
        end
        if (ev_eot || ev_esc || ev_abort) begin
            phase_next = PH_IDLE;
        end
        if (ev_soh) begin
            phase_next = PH_BLOCK;
        end
        if (ev_blk_byte) begin
            recv_block_next = in_byte_reg;
            phase_next      = PH_BLOCK_INV;
        end
        if (ev_blk_ok) begin
            phase_next = PH_PAYLOAD;
            count_next = 8'd0;
            sum_next   = 8'd0;
        end
        if (ev_payload) begin
            sum_next   = sum_reg + in_byte_reg;
            count_next = count_inc;
            if (count_inc >= PAYLOAD_LAST) begin
                phase_next = PH_CHECKSUM;
            end
        end
        if (ev_verified) begin
            phase_next = PH_VERDICT;
        end
        if (ev_fail) begin
            retries_next = retries_inc;
            if (fail_end) begin
                phase_next = PH_IDLE;
            end else begin
                phase_next   = PH_HUNT;
                elapsed_next = 24'd0;
                count_next   = 8'd0;
                sum_next     = 8'd0;
            end
        end
        if (ev_ack) begin
            retries_next   = 8'd0;
            exp_block_next = exp_block_reg + 8'd1;
            phase_next     = PH_HUNT;
            elapsed_next   = 24'd0;
            count_next     = 8'd0;
            sum_next       = 8'd0;
        end
    end

    // Results of the current item.
    always_comb begin
        grp_out.cnt = 2'd0;
        grp_out.res = '0;
        if (ev_eot) begin
            grp_out.cnt    = 2'd2;
            grp_out.res[0] = mk_res(KIND_SEND, CH_ACK, END_NONE);
            grp_out.res[1] = mk_res(KIND_ENDED, 8'd0, END_EOT);
        end else if (ev_esc || ev_abort) begin
            grp_out.cnt    = 2'd3;
            grp_out.res[0] = mk_res(KIND_SEND, CH_CAN, END_NONE);
            grp_out.res[1] = mk_res(KIND_SEND, CH_CAN, END_NONE);
            grp_out.res[2] = mk_res(KIND_ENDED, 8'd0, ev_esc ? END_CANCEL : END_SINK);
        end else if (ev_fail) begin
            grp_out.cnt    = 2'd1;
            grp_out.res[0] = fail_end ? mk_res(KIND_ENDED, 8'd0, END_RETRIES)
                                      : mk_res(KIND_SEND, CH_NAK, END_NONE);
        end else if (ev_ack) begin
            grp_out.cnt    = 2'd1;
            grp_out.res[0] = mk_res(KIND_SEND, CH_ACK, END_NONE);
        end else if (ev_verified) begin
            grp_out.cnt    = 2'd1;
            grp_out.res[0] = mk_res(KIND_VERIFIED, 8'd0, END_NONE);
        end else if (ev_payload) begin
            grp_out.cnt    = 2'd1;
            grp_out.res[0] = mk_res(KIND_PAYLOAD, in_byte_reg, END_NONE);
        end
    end

    assign grp_push = grp_out.cnt != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            timeout_reg     <= TIMEOUT_RESET;
            retry_limit_reg <= RETRY_RESET;
            verdict_en_reg  <= 1'b0;
            phase_reg       <= PH_IDLE;
            exp_block_reg   <= BLOCK_FIRST;
            recv_block_reg  <= 8'd0;
            count_reg       <= 8'd0;
            sum_reg         <= 8'd0;
            retries_reg     <= 8'd0;
            elapsed_reg     <= 24'd0;
        end else begin
            in_valid_reg   <= in_valid_next;
            phase_reg      <= phase_next;
            exp_block_reg  <= exp_block_next;
            recv_block_reg <= recv_block_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            retries_reg    <= retries_next;
            elapsed_reg    <= elapsed_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg     <= cfg_data;
                    CFG_RETRY:   retry_limit_reg <= cfg_data[7:0];
                    CFG_VERDICT: verdict_en_reg  <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_req_reg  <= req_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
            in_acc_reg  <= s_tdata[8];
        end
    end

`ifndef SYNTHESIS
    a_start_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_start |=> (phase_reg == PH_HUNT) && (exp_block_reg == BLOCK_FIRST))
        else $error("start item did not open a transfer");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PAYLOAD_LAST)
        else $error("payload count ran past the payload length");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && q_full |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held item lost while the result queue was full");
`endif

endmodule

// ===== rtl/core/xcr_resq.sv =====
// Two-entry queue of result groups that hands results out one item at a time.
module xcr_resq import xcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        grp_push,
    input  grp_t        grp_in,
    output logic        q_full,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    grp_t       grp_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] sel_reg, sel_next;

    grp_t       head;
    res_t       cur;
    logic       pop, take;

    assign head     = grp_mem[rd_ptr_reg];
    assign cur      = head.res[sel_reg];
    assign m_tvalid = count_reg != 2'd0;
    assign m_tlast  = sel_reg == 2'(head.cnt - 2'd1);
    assign m_tdata  = {6'd0, cur.status, cur.data};
    assign m_tuser  = cur.kind;
    assign q_full   = count_reg == 2'd2;
    assign take     = m_tvalid && m_tready;
    assign pop      = take && m_tlast;

    always_comb begin
        wr_ptr_next = grp_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, grp_push} - {1'b0, pop});
        sel_next    = sel_reg;
        if (pop) begin
            sel_next = 2'd0;
        end else if (take) begin
            sel_next = sel_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sel_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_push) begin
            grp_mem[wr_ptr_reg] <= grp_in;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_push |-> count_reg != 2'd2)
        else $error("result group written into a full queue");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head.cnt != 2'd0) && (sel_reg < head.cnt))
        else $error("result index outside the head group");

    a_idle_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> sel_reg == 2'd0)
        else $error("result index left over with an empty queue");
`endif

endmodule

// ===== rtl/core/xmodem_checksum_receiver.sv =====
// XMODEM checksum receiver top level: protocol engine and result queue.
//
// The block takes one item per clock cycle while the result queue is not
// full: an item is held in the input register and is processed in a single
// pass of the protocol engine, whose results (one to three per item) go into
// a two-group result queue. Items that give no result flow through at one per
// cycle while the queue is not full; results leave at one per cycle while
// m_tready is high, and the input stalls only when both queued groups are
// still waiting. Configuration writes are always ready and take effect on the
// next cycle.
module xmodem_checksum_receiver import xcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] accept, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] end_status, [15:10] zero
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic grp_push;
    logic q_full;
    grp_t grp;

    xcr_proto u_proto (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .grp_push  (grp_push),
        .grp_out   (grp)
    );

    xcr_resq u_resq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp_push (grp_push),
        .grp_in   (grp),
        .q_full   (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
